### sv/assert_macros.svh
// Assertion macros shared by the slab test RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, quiet during reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

### sv/rbst_pkg.sv
// Types and constants for the ray/box slab test.
// No dependencies.
package rbst_pkg;
    localparam int unsigned DW = 32;

    typedef struct packed {
        logic signed [DW-1:0] origin_x;
        logic signed [DW-1:0] origin_y;
        logic signed [DW-1:0] origin_z;
        logic signed [DW-1:0] dir_x;
        logic signed [DW-1:0] dir_y;
        logic signed [DW-1:0] dir_z;
        logic signed [DW-1:0] box_min_x;
        logic signed [DW-1:0] box_min_y;
        logic signed [DW-1:0] box_min_z;
        logic signed [DW-1:0] box_max_x;
        logic signed [DW-1:0] box_max_y;
        logic signed [DW-1:0] box_max_z;
    } t_in;

    typedef struct packed {
        logic                 hit;
        logic signed [DW-1:0] distance;
        logic [1:0]           outcome;
    } t_out;

    typedef enum logic [1:0] {
        OUT_HIT    = 2'd0,
        OUT_BEHIND = 2'd1,
        OUT_MISS   = 2'd2
    } t_outcome;

    localparam logic signed [DW-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DW-1:0] S32_MIN = 32'sh8000_0000;

    // Saturate sign + 64-bit magnitude to signed 32.
    function automatic logic signed [DW-1:0] sat_signed(input logic neg,
                                                        input logic [63:0] mag);
        logic [DW-1:0] m;
        m = mag[DW-1:0];
        if (!neg) begin
            sat_signed = (mag > 64'h7FFF_FFFF) ? S32_MAX : $signed(m);
        end else begin
            sat_signed = (mag > 64'h8000_0000) ? S32_MIN : $signed(-m);
        end
    endfunction
endpackage

### sv/rbst_recip.sv
// Pipelined restoring divider: 2^(2F) / |d|, one quotient bit per stage.
// Depends on rbst_pkg.
module rbst_recip #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [rbst_pkg::DW-1:0] i_dir,
    output logic signed [rbst_pkg::DW-1:0] o_inv
);
    localparam int unsigned QB = 2 * FRAC_BITS + 1;   // quotient bits
    localparam int unsigned RW = rbst_pkg::DW + 1;

    logic [rbst_pkg::DW-1:0] r_den  [QB+1];
    logic [RW-1:0]           r_rem  [QB+1];
    logic [QB-1:0]           r_quo  [QB+1];
    logic                    r_neg  [QB+1];
    logic                    r_zero [QB+1];

    // Stage 0: capture magnitude and sign.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0]  <= i_dir[rbst_pkg::DW-1] ? -i_dir : i_dir;
            r_neg[0]  <= i_dir[rbst_pkg::DW-1];
            r_zero[0] <= (i_dir == '0);
            r_rem[0]  <= '0;
            r_quo[0]  <= '0;
        end
    end

    // One quotient bit per stage; dividend is one 1 at the top bit.
    for (genvar s = 0; s < QB; s++) begin : g_div
        logic [RW:0] n_trial;
        logic [RW:0] n_sub;
        always_comb begin
            n_trial = {r_rem[s], (s == 0) ? 1'b1 : 1'b0};
            n_sub   = n_trial - {2'b00, r_den[s]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s+1]  <= r_den[s];
                r_neg[s+1]  <= r_neg[s];
                r_zero[s+1] <= r_zero[s];
                if (!n_sub[RW]) begin
                    r_rem[s+1] <= n_sub[RW-1:0];
                    r_quo[s+1] <= {r_quo[s][QB-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= n_trial[RW-1:0];
                    r_quo[s+1] <= {r_quo[s][QB-2:0], 1'b0};
                end
            end
        end
    end

    assign o_inv = r_zero[QB] ? rbst_pkg::S32_MAX
                 : rbst_pkg::sat_signed(r_neg[QB], 64'(r_quo[QB]));
endmodule

### sv/rbst_slab.sv
// Slab distance: (corner - origin) * inv >> F, saturated; two register stages.
// Depends on rbst_pkg.
module rbst_slab #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [rbst_pkg::DW-1:0] i_corner,
    input  logic signed [rbst_pkg::DW-1:0] i_orig,
    input  logic signed [rbst_pkg::DW-1:0] i_inv,
    output logic signed [rbst_pkg::DW-1:0] o_t
);
    logic signed [rbst_pkg::DW:0] n_diff;
    logic [rbst_pkg::DW:0]        r_dmag;
    logic [rbst_pkg::DW-1:0]      r_imag;
    logic                         r_neg;
    logic [64:0]                  r_prod;
    logic                         r_neg2;

    assign n_diff = {i_corner[rbst_pkg::DW-1], i_corner} - {i_orig[rbst_pkg::DW-1], i_orig};

    // Magnitudes and result sign.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dmag <= n_diff[rbst_pkg::DW] ? -n_diff : n_diff;
            r_imag <= i_inv[rbst_pkg::DW-1] ? -i_inv : i_inv;
            r_neg  <= n_diff[rbst_pkg::DW] ^ i_inv[rbst_pkg::DW-1];
        end
    end

    // 33x32 unsigned product.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= 65'(r_dmag) * 65'(r_imag);
            r_neg2 <= r_neg;
        end
    end

    logic [64:0] n_sh;
    assign n_sh = r_prod >> FRAC_BITS;
    assign o_t  = rbst_pkg::sat_signed(r_neg2, n_sh[63:0]);
endmodule

### sv/ray_box_slab_test_unit.sv
// Ray/box slab test, one beat per cycle while not stalled, fully pipelined.
// Stages in order: reciprocal divider, inverse register, multiply, min/max trees,
// outcome; throughput one beat per clock while not stalled.
// A stall freezes all stages. Reset (synchronous, active low) clears valid bits only.
// Depends on rbst_pkg, rbst_recip, rbst_slab, assert_macros.svh.
`include "assert_macros.svh"
module ray_box_slab_test_unit #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rbst_pkg::t_in    i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output rbst_pkg::t_out   o_data
);
    localparam int unsigned DW  = rbst_pkg::DW;
    localparam int unsigned RL  = 2 * FRAC_BITS + 2;   // divider latency
    localparam int unsigned LAT = RL + 7;

    logic   r_v [LAT];
    logic   en;
    assign en      = !r_v[LAT-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_v[LAT-1];

    // Valid shift line.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_v[k] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < LAT; k++) r_v[k] <= r_v[k-1];
        end
    end

    // Delay origins and corners alongside the divider and the inverse register.
    rbst_pkg::t_in r_d [RL+1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d[0] <= i_data;
            for (int k = 1; k < RL + 1; k++) r_d[k] <= r_d[k-1];
        end
    end

    logic signed [DW-1:0] inv [3];
    logic signed [DW-1:0] dirs [3];
    assign dirs[0] = i_data.dir_x;
    assign dirs[1] = i_data.dir_y;
    assign dirs[2] = i_data.dir_z;

    logic signed [DW-1:0] r_inv [3];
    for (genvar a = 0; a < 3; a++) begin : g_rcp
        rbst_recip #(.FRAC_BITS(FRAC_BITS)) u_rcp (
            .i_clk(i_clk), .i_en(en), .i_dir(dirs[a]), .o_inv(inv[a]));
        always_ff @(posedge i_clk) begin
            if (en) r_inv[a] <= inv[a];
        end
    end

    rbst_pkg::t_in dd;
    assign dd = r_d[RL];
    logic signed [DW-1:0] orig [3], cmin [3], cmax [3];
    assign orig[0] = dd.origin_x;  assign orig[1] = dd.origin_y;  assign orig[2] = dd.origin_z;
    assign cmin[0] = dd.box_min_x; assign cmin[1] = dd.box_min_y; assign cmin[2] = dd.box_min_z;
    assign cmax[0] = dd.box_max_x; assign cmax[1] = dd.box_max_y; assign cmax[2] = dd.box_max_z;

    logic signed [DW-1:0] ta [3], tb [3];
    logic signed [DW-1:0] r_ta [3], r_tb [3];
    logic signed [DW-1:0] r_lo [3], r_hi [3];
    for (genvar a = 0; a < 3; a++) begin : g_slab
        rbst_slab #(.FRAC_BITS(FRAC_BITS)) u_a (
            .i_clk(i_clk), .i_en(en), .i_corner(cmin[a]), .i_orig(orig[a]),
            .i_inv(r_inv[a]), .o_t(ta[a]));
        rbst_slab #(.FRAC_BITS(FRAC_BITS)) u_b (
            .i_clk(i_clk), .i_en(en), .i_corner(cmax[a]), .i_orig(orig[a]),
            .i_inv(r_inv[a]), .o_t(tb[a]));
        // Register slab distances, then per-axis near/far.
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ta[a] <= ta[a];
                r_tb[a] <= tb[a];
                r_lo[a] <= (r_ta[a] < r_tb[a]) ? r_ta[a] : r_tb[a];
                r_hi[a] <= (r_ta[a] > r_tb[a]) ? r_ta[a] : r_tb[a];
            end
        end
    end

    // Combine axes: tmin = max of near, tmax = min of far.
    logic signed [DW-1:0] r_tmin, r_tmax;
    logic signed [DW-1:0] n_m01, n_x01;
    assign n_m01 = (r_lo[0] > r_lo[1]) ? r_lo[0] : r_lo[1];
    assign n_x01 = (r_hi[0] < r_hi[1]) ? r_hi[0] : r_hi[1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tmin <= (n_m01 > r_lo[2]) ? n_m01 : r_lo[2];
            r_tmax <= (n_x01 < r_hi[2]) ? n_x01 : r_hi[2];
        end
    end

    // Outcome select, output register.
    always_ff @(posedge i_clk) begin
        if (en) begin
            priority if (r_tmax < 0) begin
                o_data.hit      <= 1'b0;
                o_data.distance <= r_tmax;
                o_data.outcome  <= rbst_pkg::OUT_BEHIND;
            end else if (r_tmin > r_tmax) begin
                o_data.hit      <= 1'b0;
                o_data.distance <= r_tmax;
                o_data.outcome  <= rbst_pkg::OUT_MISS;
            end else begin
                o_data.hit      <= 1'b1;
                o_data.distance <= r_tmin;
                o_data.outcome  <= rbst_pkg::OUT_HIT;
            end
        end
    end

    `ASSERT_IMPL(a_hit_code, i_clk, i_rst_n, o_valid,
        o_data.hit == (o_data.outcome == rbst_pkg::OUT_HIT))
    `ASSERT_IMPL(a_no_code3, i_clk, i_rst_n, o_valid, o_data.outcome != 2'd3)
    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_data))
endmodule
